@@ sv/jelt_pkg.sv @@
// ----------------------------------------------------------------------------
// jelt_pkg
// Shared types and constants for the journal extent lookup table.
// ----------------------------------------------------------------------------
package jelt_pkg;

   localparam int MODE_W     = 2;
   localparam int LBA_W      = 12;
   localparam int LEN_W      = 7;
   localparam int JLBA_W     = 32;
   localparam int FID_W      = 32;
   localparam int STS_W      = 2;

   localparam int LBA_LSB    = 0;
   localparam int LEN_LSB    = LBA_LSB + LBA_W;
   localparam int JLBA_LSB   = LEN_LSB + LEN_W;
   localparam int FID_LSB    = JLBA_LSB + JLBA_W;
   localparam int REQ_BITS   = FID_LSB + FID_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_BITS   = 1 + JLBA_W + STS_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_INVAL  = 2'd2
   } mode_type;

   typedef enum logic [STS_W-1:0] {
      STS_DONE = 2'd0,
      STS_FULL = 2'd1,
      STS_CLIP = 2'd2
   } sts_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LK_TXN,
      ST_LK_CMP,
      ST_ADD_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [FID_W-1:0]  file_id;
      logic [JLBA_W-1:0] journal_lba;
      logic [LEN_W-1:0]  length;
      logic [LBA_W-1:0]  start_lba;
   } txn_entry_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      sts_type              status;
      logic [JLBA_W-1:0]    found_journal_lba;
      logic                 hit;
   } rsp_word_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic txn_rd;
      logic add_wr;
      logic rsp_load_cmp;
      logic rsp_load_sts;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              full;
      logic              len_zero;
      logic              add_last;
      logic              clear_last;
      logic              rsp_free;
   } stat_type;

endpackage

@@ sv/jelt_ctrl.sv @@
// ----------------------------------------------------------------------------
// jelt_ctrl
// Sequencer for map clearing, add runs, lookups and response hand-off.
// ----------------------------------------------------------------------------
module jelt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  jelt_pkg::stat_type stat,
   output jelt_pkg::cmd_type  cmd
);

   jelt_pkg::state_type state_ff;
   jelt_pkg::state_type state_in;
   jelt_pkg::mode_type  mode;

   assign mode = jelt_pkg::mode_type'(stat.mode);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jelt_pkg::ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = jelt_pkg::ST_IDLE;
            end
         end
         jelt_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (mode == jelt_pkg::MODE_LOOKUP) begin
                  state_in = jelt_pkg::ST_LK_TXN;
               end else if (mode == jelt_pkg::MODE_ADD && !stat.full && !stat.len_zero) begin
                  state_in = jelt_pkg::ST_ADD_RUN;
               end else begin
                  state_in = jelt_pkg::ST_FINISH;
               end
            end
         end
         jelt_pkg::ST_LK_TXN: begin
            state_in = jelt_pkg::ST_LK_CMP;
         end
         jelt_pkg::ST_LK_CMP: begin
            if (stat.rsp_free) begin
               state_in = jelt_pkg::ST_IDLE;
            end
         end
         jelt_pkg::ST_ADD_RUN: begin
            if (stat.add_last) begin
               state_in = jelt_pkg::ST_FINISH;
            end
         end
         jelt_pkg::ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = jelt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jelt_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         jelt_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         jelt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         jelt_pkg::ST_LK_TXN: begin
            cmd.txn_rd = 1'b1;
         end
         jelt_pkg::ST_LK_CMP: begin
            cmd.rsp_load_cmp = stat.rsp_free;
         end
         jelt_pkg::ST_ADD_RUN: begin
            cmd.add_wr = 1'b1;
         end
         jelt_pkg::ST_FINISH: begin
            cmd.rsp_load_sts = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jelt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/jelt_dpath.sv @@
// ----------------------------------------------------------------------------
// jelt_dpath
// Transaction table, per-block reference map, lookup compare and response
// register.
// ----------------------------------------------------------------------------
module jelt_dpath #(
   parameter int TXN_DEPTH = 256,
   parameter int LBA_SPACE = 4096,
   parameter int MAX_RUN   = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [jelt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [jelt_pkg::MODE_W-1:0]       req_tuser,
   output logic [jelt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  jelt_pkg::cmd_type                 cmd,
   output jelt_pkg::stat_type                stat
);

   localparam int IW = $clog2(TXN_DEPTH);
   localparam int CW = $clog2(TXN_DEPTH + 1);
   localparam int AW = $clog2(LBA_SPACE);
   localparam int SW = jelt_pkg::LBA_W + 1;

   // reference map word: valid mark above the transaction index
   logic [IW:0]                   ref_mem [LBA_SPACE];
   jelt_pkg::txn_entry_type       txn_mem [TXN_DEPTH];

   logic [jelt_pkg::LBA_W-1:0]    req_lba;
   logic [jelt_pkg::LEN_W-1:0]    req_len;
   logic [jelt_pkg::JLBA_W-1:0]   req_jlba;
   logic [jelt_pkg::FID_W-1:0]    req_fid;
   jelt_pkg::mode_type            req_mode;
   logic [jelt_pkg::LEN_W-1:0]    len_sat;
   logic                          req_inmap;
   logic                          full;
   logic                          add_new;

   logic [CW-1:0]                 count_ff, count_in;
   logic [IW-1:0]                 slot_ff, slot_in;
   logic [jelt_pkg::LBA_W-1:0]    lba_ff, lba_in;
   logic [jelt_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [jelt_pkg::FID_W-1:0]    fid_ff, fid_in;
   logic [jelt_pkg::LEN_W-1:0]    idx_ff, idx_in;
   jelt_pkg::sts_type             sts_ff, sts_in;
   logic                          inmap_ff, inmap_in;
   logic                          lkok_ff, lkok_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic [IW:0]                   ref_rd_ff;
   jelt_pkg::txn_entry_type       txn_rd_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   jelt_pkg::rsp_word_type        rsp_data_ff, rsp_data_in;

   logic [SW-1:0]                 add_sum;
   logic                          add_inmap;
   logic                          ref_wr_en;
   logic [AW-1:0]                 ref_wr_addr;
   logic [IW:0]                   ref_wr_data;
   jelt_pkg::txn_entry_type       txn_wr_data;

   logic [SW-1:0]                 txn_end;
   logic [SW-1:0]                 req_end;
   logic                          hit;

   assign req_lba  = req_tdata[jelt_pkg::LBA_LSB  +: jelt_pkg::LBA_W];
   assign req_len  = req_tdata[jelt_pkg::LEN_LSB  +: jelt_pkg::LEN_W];
   assign req_jlba = req_tdata[jelt_pkg::JLBA_LSB +: jelt_pkg::JLBA_W];
   assign req_fid  = req_tdata[jelt_pkg::FID_LSB  +: jelt_pkg::FID_W];
   assign req_mode = jelt_pkg::mode_type'(req_tuser);

   assign len_sat   = (32'(req_len) > 32'(MAX_RUN)) ? jelt_pkg::LEN_W'(MAX_RUN) : req_len;
   assign req_inmap = 32'(req_lba) < 32'(LBA_SPACE);
   assign full      = count_ff == CW'(TXN_DEPTH);
   assign add_new   = cmd.accept && req_mode == jelt_pkg::MODE_ADD && !full;

   assign add_sum   = {1'b0, lba_ff} + SW'(idx_ff);
   assign add_inmap = 32'(add_sum) < 32'(LBA_SPACE);

   // single write port shared by clearing, add runs and invalidation
   always_comb begin
      ref_wr_en   = 1'b0;
      ref_wr_addr = AW'(req_lba);
      ref_wr_data = '0;
      priority if (cmd.clear_wr) begin
         ref_wr_en   = 1'b1;
         ref_wr_addr = clr_ff;
      end else if (cmd.add_wr) begin
         ref_wr_en   = add_inmap;
         ref_wr_addr = AW'(add_sum);
         ref_wr_data = {1'b1, slot_ff};
      end else if (cmd.accept) begin
         ref_wr_en   = req_mode == jelt_pkg::MODE_INVAL && req_inmap;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_wr_en) begin
         ref_mem[ref_wr_addr] <= ref_wr_data;
      end
      if (cmd.accept) begin
         ref_rd_ff <= ref_mem[AW'(req_lba)];
      end
   end

   always_comb begin
      txn_wr_data.file_id     = req_fid;
      txn_wr_data.journal_lba = req_jlba;
      txn_wr_data.length      = len_sat;
      txn_wr_data.start_lba   = req_lba;
   end

   always_ff @(posedge clock) begin
      if (add_new) begin
         txn_mem[IW'(count_ff)] <= txn_wr_data;
      end
      if (cmd.txn_rd) begin
         txn_rd_ff <= txn_mem[ref_rd_ff[IW-1:0]];
      end
   end

   assign txn_end = {1'b0, txn_rd_ff.start_lba} + SW'(txn_rd_ff.length);
   assign req_end = {1'b0, lba_ff} + SW'(len_ff);
   assign hit     = lkok_ff && txn_rd_ff.file_id == fid_ff &&
                    txn_rd_ff.start_lba <= lba_ff && txn_end >= req_end;

   always_comb begin
      count_in     = count_ff;
      slot_in      = slot_ff;
      lba_in       = lba_ff;
      len_in       = len_ff;
      fid_in       = fid_ff;
      idx_in       = idx_ff;
      sts_in       = sts_ff;
      inmap_in     = inmap_ff;
      lkok_in      = lkok_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.clear_wr) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.accept) begin
         slot_in  = IW'(count_ff);
         lba_in   = req_lba;
         len_in   = (req_mode == jelt_pkg::MODE_ADD) ? len_sat : req_len;
         fid_in   = req_fid;
         idx_in   = '0;
         inmap_in = req_inmap;
         sts_in   = (req_mode == jelt_pkg::MODE_ADD && full) ? jelt_pkg::STS_FULL
                                                             : jelt_pkg::STS_DONE;
         if (add_new) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.txn_rd) begin
         lkok_in = inmap_ff && ref_rd_ff[IW];
      end
      if (cmd.add_wr) begin
         idx_in = idx_ff + jelt_pkg::LEN_W'(1);
         if (!add_inmap) begin
            sts_in = jelt_pkg::STS_CLIP;
         end
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load_cmp) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.pad               = '0;
         rsp_data_in.status            = jelt_pkg::STS_DONE;
         rsp_data_in.found_journal_lba = hit ? txn_rd_ff.journal_lba : '0;
         rsp_data_in.hit               = hit;
      end else if (cmd.rsp_load_sts) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.pad               = '0;
         rsp_data_in.status            = sts_ff;
         rsp_data_in.found_journal_lba = '0;
         rsp_data_in.hit               = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      lba_ff      <= lba_in;
      len_ff      <= len_in;
      fid_ff      <= fid_in;
      idx_ff      <= idx_in;
      sts_ff      <= sts_in;
      inmap_ff    <= inmap_in;
      lkok_ff     <= lkok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      stat.mode       = req_tuser;
      stat.full       = full;
      stat.len_zero   = len_sat == '0;
      stat.add_last   = jelt_pkg::LEN_W'(idx_ff + jelt_pkg::LEN_W'(1)) == len_ff;
      stat.clear_last = clr_ff == AW'(LBA_SPACE - 1);
      stat.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

@@ sv/journal_extent_lookup_table_core.sv @@
// ----------------------------------------------------------------------------
// journal_extent_lookup_table_core
// Journal transaction table with a per-block owner map: add, lookup and
// invalidate requests, one response per request.
// ----------------------------------------------------------------------------
// steps: lookup reads the map, then the table, then compares; invalidate and
//   rejected add go straight to the response; add writes the map once per block
// throughput: one request at a time, the next taken right after the response
//   is loaded; loading waits while the response side is not free
// reset: synchronous; the map valid marks are cleared by a pass over every
//   map word after reset, during which req_tready stays low
module journal_extent_lookup_table_core #(
   parameter int TXN_DEPTH = 256,
   parameter int LBA_SPACE = 4096,
   parameter int MAX_RUN   = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // lba, run_length, journal_lba, file_id
   input  logic [jelt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic [jelt_pkg::MODE_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, found_journal_lba, status
   output logic [jelt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   jelt_pkg::cmd_type  cmd;
   jelt_pkg::stat_type stat;

   jelt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   jelt_dpath #(
      .TXN_DEPTH (TXN_DEPTH),
      .LBA_SPACE (LBA_SPACE),
      .MAX_RUN   (MAX_RUN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

@@ sv/jelt_checker.sv @@
// ----------------------------------------------------------------------------
// jelt_checker
// Port-level checks for the journal extent lookup table.
// ----------------------------------------------------------------------------
module jelt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [jelt_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in progress");

   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[34:33] == jelt_pkg::STS_DONE)
      else $error("hit with nonzero status");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("journal lba nonzero on miss");

endmodule

bind journal_extent_lookup_table_core jelt_checker u_jelt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/jelt_checker.sv @@
// ----------------------------------------------------------------------------
// jelt_tb_checker
// Watches the request and response streams of the journal extent lookup
// table, keeps its own copy of the transaction table and owner map, predicts
// the response for every accepted request and compares each field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module jelt_tb_checker
   import jelt_pkg::*;
#(
   parameter int TXN_DEPTH = 256,
   parameter int LBA_SPACE = 4096,
   parameter int MAX_RUN   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatch_count,
   output int                    outstanding
);

   typedef struct {
      logic              hit;
      logic [JLBA_W-1:0] journal_lba;
      sts_type           status;
   } outcome_type;

   logic [LBA_W-1:0]  tbl_start [TXN_DEPTH];
   logic [LEN_W-1:0]  tbl_len   [TXN_DEPTH];
   logic [JLBA_W-1:0] tbl_jlba  [TXN_DEPTH];
   logic [FID_W-1:0]  tbl_fid   [TXN_DEPTH];
   bit                tbl_valid [TXN_DEPTH];
   int                tbl_count;
   int                owner_idx   [LBA_SPACE];
   bit                owner_valid [LBA_SPACE];

   outcome_type  outcome_q [$];
   outcome_type  want;
   rsp_word_type got;

   function automatic outcome_type predict_outcome(
      input logic [MODE_W-1:0] mode,
      input logic [LBA_W-1:0]  lba,
      input logic [LEN_W-1:0]  len,
      input logic [JLBA_W-1:0] jlba,
      input logic [FID_W-1:0]  fid
   );
      outcome_type o;
      int n;
      int a;
      int t;
      o.hit = 1'b0;
      o.journal_lba = '0;
      o.status = STS_DONE;
      case (mode)
         MODE_ADD: begin
            if (tbl_count >= TXN_DEPTH) begin
               o.status = STS_FULL;
            end else begin
               n = (int'(len) > MAX_RUN) ? MAX_RUN : int'(len);
               tbl_start[tbl_count] = lba;
               tbl_len[tbl_count]   = LEN_W'(n);
               tbl_jlba[tbl_count]  = jlba;
               tbl_fid[tbl_count]   = fid;
               tbl_valid[tbl_count] = 1'b1;
               for (int i = 0; i < n; i++) begin
                  a = int'(lba) + i;
                  if (a >= LBA_SPACE) begin
                     o.status = STS_CLIP;
                  end else begin
                     owner_idx[a]   = tbl_count;
                     owner_valid[a] = 1'b1;
                  end
               end
               tbl_count++;
            end
         end
         MODE_LOOKUP: begin
            if (int'(lba) < LBA_SPACE && owner_valid[lba]) begin
               t = owner_idx[lba];
               if (t < TXN_DEPTH && tbl_valid[t] && tbl_fid[t] == fid &&
                   int'(tbl_start[t]) <= int'(lba) &&
                   int'(tbl_start[t]) + int'(tbl_len[t]) >= int'(lba) + int'(len)) begin
                  o.hit = 1'b1;
                  o.journal_lba = tbl_jlba[t];
               end
            end
         end
         MODE_INVAL: begin
            if (int'(lba) < LBA_SPACE) owner_valid[lba] = 1'b0;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] wanted);
      $display("%0t: %s: got 0x%08h, want 0x%08h", $time, what, seen, wanted);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
         foreach (owner_valid[i]) owner_valid[i] = 1'b0;
         tbl_count = 0;
         outcome_q.delete();
         mismatch_count = 0;
         outstanding <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(predict_outcome(req_tuser,
               req_tdata[LBA_LSB +: LBA_W], req_tdata[LEN_LSB +: LEN_W],
               req_tdata[JLBA_LSB +: JLBA_W], req_tdata[FID_LSB +: FID_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_word_type'(rsp_tdata);
            if (outcome_q.size() == 0) begin
               report_mismatch("response without request", 32'(rsp_tdata), '0);
            end else begin
               want = outcome_q.pop_front();
               if (got.hit !== want.hit)
                  report_mismatch("hit", 32'(got.hit), 32'(want.hit));
               if (got.found_journal_lba !== want.journal_lba)
                  report_mismatch("found_journal_lba", got.found_journal_lba,
                                  want.journal_lba);
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
            end
         end
         outstanding <= outcome_q.size();
      end
   end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the journal extent lookup table: a directed pass over the
// edge cases, then random add/lookup/invalidate sequences, a fill to table
// full, random stalls on both streams and one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import jelt_pkg::*;

   localparam int TXN_DEPTH = 256;
   localparam int LBA_SPACE = 4096;
   localparam int MAX_RUN   = 64;
   localparam int N_RANDOM  = 420;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      int                lba;
      int                len;
      logic [FID_W-1:0]  fid;
   } run_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatch_count;
   int                    outstanding;

   int                    sent_count = 0;
   int                    adds_sent  = 0;
   bit                    hold_done  = 1'b0;
   run_type               known_runs [$];

   journal_extent_lookup_table_core #(
      .TXN_DEPTH (TXN_DEPTH),
      .LBA_SPACE (LBA_SPACE),
      .MAX_RUN   (MAX_RUN)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   jelt_tb_checker #(
      .TXN_DEPTH (TXN_DEPTH),
      .LBA_SPACE (LBA_SPACE),
      .MAX_RUN   (MAX_RUN)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_add_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 0;
      if (r < 70) return $urandom_range(1, 16);
      if (r < 90) return $urandom_range(17, 64);
      return $urandom_range(65, 127);
   endfunction

   // one request, held until accepted, then an optional idle gap
   task automatic send_req(input logic [MODE_W-1:0] m, input int lba, input int len,
                           input logic [JLBA_W-1:0] jlba, input logic [FID_W-1:0] fid);
      logic [REQ_DATA_W-1:0] d;
      run_type run;
      int gap;
      d = '0;
      d[LBA_LSB +: LBA_W]   = LBA_W'(lba);
      d[LEN_LSB +: LEN_W]   = LEN_W'(len);
      d[JLBA_LSB +: JLBA_W] = jlba;
      d[FID_LSB +: FID_W]   = fid;
      if (m == MODE_ADD) begin
         if (adds_sent < TXN_DEPTH && (len & 8'h7f) != 0) begin
            run.lba = lba & 12'hfff;
            run.len = ((len & 8'h7f) > MAX_RUN) ? MAX_RUN : (len & 8'h7f);
            run.fid = fid;
            known_runs.push_back(run);
         end
         adds_sent++;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= m;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic probe_run(input run_type run);
      int off;
      int la;
      int rem;
      int qlen;
      logic [FID_W-1:0] fid;
      off = $urandom_range(0, run.len - 1);
      la = run.lba + off;
      if (la > LBA_SPACE - 1) la = LBA_SPACE - 1;
      rem = run.lba + run.len - la;
      qlen = $urandom_range(0, rem + 2);
      if (qlen > 127) qlen = 127;
      fid = ($urandom_range(0, 99) < 85) ? run.fid : $urandom;
      send_req(MODE_LOOKUP, la, qlen, $urandom, fid);
   endtask

   // response side: random stalls, one long hold-off to back up the request side
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (!hold_done && sent_count >= 150) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            stall = 600;
         end else if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            stall = $urandom_range(0, 40);
         end else begin
            rsp_tready <= 1'b0;
            stall = pick_gap();
         end
         repeat (stall) @(posedge clock);
      end
   end

   initial begin
      #18000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int r;
      int n;
      run_type run;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_req(MODE_LOOKUP, 0, 1, 32'h0, 32'h0);
      send_req(MODE_ADD, 0, 64, 32'hffff_ffff, 32'hffff_ffff);
      send_req(MODE_LOOKUP, 0, 64, 32'h0, 32'hffff_ffff);
      send_req(MODE_LOOKUP, 0, 65, 32'h0, 32'hffff_ffff);
      send_req(MODE_LOOKUP, 10, 0, 32'h0, 32'h0);
      // run past the map end
      send_req(MODE_ADD, 4090, 10, 32'h0, 32'h0);
      send_req(MODE_LOOKUP, 4095, 1, 32'h0, 32'h0);
      // overlong run, saturated and clipped
      send_req(MODE_ADD, 4095, 127, 32'h1234_5678, 32'h0);
      send_req(MODE_ADD, 100, 127, 32'hdead_beef, 32'h5);
      send_req(MODE_LOOKUP, 100, 64, 32'h0, 32'h5);
      send_req(MODE_LOOKUP, 100, 65, 32'h0, 32'h5);
      send_req(MODE_LOOKUP, 163, 1, 32'h0, 32'h5);
      send_req(MODE_INVAL, 100, 0, 32'h0, 32'h0);
      send_req(MODE_LOOKUP, 100, 1, 32'h0, 32'h5);
      send_req(MODE_LOOKUP, 101, 1, 32'h0, 32'h5);
      send_req(MODE_INVAL, 4095, 127, 32'hffff_ffff, 32'hffff_ffff);
      send_req(MODE_UNUSED, 4095, 127, 32'hffff_ffff, 32'hffff_ffff);
      // zero length add stores a transaction with no references
      send_req(MODE_ADD, 200, 0, 32'h0bad_cafe, 32'h7);
      send_req(MODE_LOOKUP, 200, 0, 32'h0, 32'h7);
      // overlapping add takes over part of an older run
      send_req(MODE_ADD, 120, 8, 32'h0000_0120, 32'h6);
      send_req(MODE_LOOKUP, 110, 20, 32'h0, 32'h5);
      send_req(MODE_LOOKUP, 120, 1, 32'h0, 32'h5);
      send_req(MODE_LOOKUP, 120, 8, 32'h0, 32'h6);

      // random part
      while (sent_count < N_RANDOM + 23) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            run.lba = $urandom_range(0, LBA_SPACE - 1);
            run.len = pick_add_len();
            run.fid = $urandom;
            send_req(MODE_ADD, run.lba, run.len, $urandom, run.fid);
            if (run.len > MAX_RUN) run.len = MAX_RUN;
            if (run.len > 0) begin
               n = $urandom_range(1, 3);
               repeat (n) probe_run(run);
               if ($urandom_range(0, 3) == 0) begin
                  send_req(MODE_INVAL, run.lba + $urandom_range(0, run.len - 1),
                           $urandom_range(0, 127), $urandom, $urandom);
                  probe_run(run);
               end
            end
         end else if (r < 80 && known_runs.size() > 0) begin
            probe_run(known_runs[$urandom_range(0, known_runs.size() - 1)]);
         end else if (r < 90 && known_runs.size() > 0) begin
            run = known_runs[$urandom_range(0, known_runs.size() - 1)];
            send_req(MODE_INVAL, run.lba + $urandom_range(0, run.len - 1),
                     $urandom_range(0, 127), $urandom, $urandom);
         end else begin
            send_req(MODE_W'($urandom_range(0, 3)), $urandom_range(0, LBA_SPACE - 1),
                     $urandom_range(0, 127), $urandom, $urandom);
         end
      end

      // fill the table and go past full
      while (adds_sent < TXN_DEPTH + 6)
         send_req(MODE_ADD, $urandom_range(0, LBA_SPACE - 1), $urandom_range(0, 8),
                  $urandom, $urandom);
      repeat (20) probe_run(known_runs[$urandom_range(0, known_runs.size() - 1)]);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
